FILE: hw/rtl/imm_pkg.sv
// Shared types, constants and helpers for the integer matrix multiplier.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package imm_pkg;

   // Data and index widths fixed by the interface
   localparam int DATA_W      = 32;
   localparam int DIM_W       = 4;
   localparam int IDX_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int MAX_DIM_DEF = 8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B = 3'd3;

   // Result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             load;       // store the accepted word
      logic             emit_mis;   // put a mismatch result in the output register
      logic             issue;      // read one A/B pair into the MAC pipeline
      logic             acc_clear;  // start a new dot product
      logic             emit;       // put the finished sum in the output register
      logic             emit_last;  // the emitted sum is the final one
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] idx;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic             mismatch;   // inner dimensions differ
      logic             last_load;  // the next word completes B
      logic             busy;       // MAC pipeline holds work
      logic             out_free;   // output register can take a result
      logic [DIM_W-1:0] rows_a;
      logic [DIM_W-1:0] cols_a;
      logic [DIM_W-1:0] cols_b;
   } dp_status_type;

   // Clamp a dimension register to 1..max_d
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] max_d);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > max_d) begin
         r = max_d;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/imm_datapath.sv
// Datapath: dimension registers, load counters, A and B stores, MAC pipeline
// and the output register. Depends on imm_pkg.
`timescale 1ns / 1ps

module imm_datapath #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [imm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [imm_pkg::DIM_W-1:0]          csr_wr_data,
   input  logic signed [imm_pkg::DATA_W-1:0]  req_element_value,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [imm_pkg::IDX_W-1:0]          rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]          rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0]  rsp_product_value,
   output logic                               rsp_status,
   output logic                               rsp_last_flag,
   input  imm_pkg::ctrl_cmd_type              cmd,
   output imm_pkg::dp_status_type             stat
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [imm_pkg::DIM_W-1:0] MAX_D = imm_pkg::DIM_W'(MAX_DIM);

   // Dimension registers
   logic [imm_pkg::DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [imm_pkg::DIM_W-1:0] ra, ca, rb, cb;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= imm_pkg::DIM_W'(1);
         cols_a_ff <= imm_pkg::DIM_W'(1);
         rows_b_ff <= imm_pkg::DIM_W'(1);
         cols_b_ff <= imm_pkg::DIM_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            imm_pkg::REG_ROWS_A: rows_a_ff <= csr_wr_data;
            imm_pkg::REG_COLS_A: cols_a_ff <= csr_wr_data;
            imm_pkg::REG_ROWS_B: rows_b_ff <= csr_wr_data;
            imm_pkg::REG_COLS_B: cols_b_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign ra = imm_pkg::eff_dim(rows_a_ff, MAX_D);
   assign ca = imm_pkg::eff_dim(cols_a_ff, MAX_D);
   assign rb = imm_pkg::eff_dim(rows_b_ff, MAX_D);
   assign cb = imm_pkg::eff_dim(cols_b_ff, MAX_D);

   // Load position: phase (A or B), row and column
   logic                      ld_b_ff, ld_b_in;
   logic [imm_pkg::IDX_W-1:0] ld_r_ff, ld_r_in, ld_c_ff, ld_c_in;
   logic [imm_pkg::DIM_W-1:0] ld_rows, ld_cols;
   logic                      col_end, row_end;

   always_comb begin
      ld_rows = ld_b_ff ? rb : ra;
      ld_cols = ld_b_ff ? cb : ca;
      col_end = (imm_pkg::DIM_W'(ld_c_ff) + imm_pkg::DIM_W'(1)) == ld_cols;
      row_end = (imm_pkg::DIM_W'(ld_r_ff) + imm_pkg::DIM_W'(1)) == ld_rows;
      ld_b_in = ld_b_ff;
      ld_r_in = ld_r_ff;
      ld_c_in = ld_c_ff;
      if (csr_wr_en) begin
         ld_b_in = 1'b0;
         ld_r_in = '0;
         ld_c_in = '0;
      end else if (cmd.load) begin
         if (!col_end) begin
            ld_c_in = ld_c_ff + imm_pkg::IDX_W'(1);
         end else begin
            ld_c_in = '0;
            if (!row_end) begin
               ld_r_in = ld_r_ff + imm_pkg::IDX_W'(1);
            end else begin
               ld_r_in = '0;
               ld_b_in = !ld_b_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_b_ff <= 1'b0;
         ld_r_ff <= '0;
         ld_c_ff <= '0;
      end else begin
         ld_b_ff <= ld_b_in;
         ld_r_ff <= ld_r_in;
         ld_c_ff <= ld_c_in;
      end
   end

   // Addresses: row * MAX_DIM + column
   logic [ADDR_W-1:0] ld_addr, rd_addr_a, rd_addr_b;

   assign ld_addr   = ADDR_W'(int'(ld_r_ff) * MAX_DIM + int'(ld_c_ff));
   assign rd_addr_a = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.idx));
   assign rd_addr_b = ADDR_W'(int'(cmd.idx) * MAX_DIM + int'(cmd.col));

   // A and B stores, registered read
   logic signed [imm_pkg::DATA_W-1:0] mem_a [DEPTH];
   logic signed [imm_pkg::DATA_W-1:0] mem_b [DEPTH];
   logic signed [imm_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && !ld_b_ff) begin
         mem_a[ld_addr] <= req_element_value;
      end
      if (cmd.load && ld_b_ff) begin
         mem_b[ld_addr] <= req_element_value;
      end
      rd_a_ff <= mem_a[rd_addr_a];
      rd_b_ff <= mem_b[rd_addr_b];
   end

   // MAC pipeline: read, multiply, accumulate
   logic                              v1_ff, v2_ff;
   logic signed [imm_pkg::DATA_W-1:0] prod_ff, acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= imm_pkg::DATA_W'(rd_a_ff * rd_b_ff);
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // Output register
   logic out_valid_ff;
   logic out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_mis) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_mis) begin
         rsp_out_row       <= '0;
         rsp_out_col       <= '0;
         rsp_product_value <= '0;
         rsp_status        <= imm_pkg::STATUS_MISMATCH;
         rsp_last_flag     <= 1'b1;
      end else if (cmd.emit) begin
         rsp_out_row       <= cmd.row;
         rsp_out_col       <= cmd.col;
         rsp_product_value <= acc_ff;
         rsp_status        <= imm_pkg::STATUS_OK;
         rsp_last_flag     <= cmd.emit_last;
      end
   end

   assign rsp_valid = out_valid_ff;

   // Status to the controller
   always_comb begin
      stat.mismatch  = (ca != rb);
      stat.last_load = ld_b_ff && col_end && row_end;
      stat.busy      = v1_ff || v2_ff;
      stat.out_free  = out_free;
      stat.rows_a    = ra;
      stat.cols_a    = ca;
      stat.cols_b    = cb;
   end

endmodule

FILE: hw/rtl/imm_controller.sv
// Controller: sequences loading, the dot-product walk and result emission.
// Depends on imm_pkg; talks to imm_datapath through command and status.
`timescale 1ns / 1ps

module imm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  imm_pkg::dp_status_type stat,
   output imm_pkg::ctrl_cmd_type  cmd
);

   imm_pkg::state_type        state_ff, state_in;
   logic [imm_pkg::IDX_W-1:0] row_ff, row_in, col_ff, col_in, idx_ff, idx_in;
   logic                      row_end, col_end, idx_end;

   // Hold state and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         idx_ff   <= idx_in;
      end
   end

   // Next state and commands
   always_comb begin
      row_end = (imm_pkg::DIM_W'(row_ff) + imm_pkg::DIM_W'(1)) == stat.rows_a;
      col_end = (imm_pkg::DIM_W'(col_ff) + imm_pkg::DIM_W'(1)) == stat.cols_b;
      idx_end = (imm_pkg::DIM_W'(idx_ff) + imm_pkg::DIM_W'(1)) == stat.cols_a;

      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      idx_in   = idx_ff;
      req_stall = 1'b1;

      cmd           = '0;
      cmd.row       = row_ff;
      cmd.col       = col_ff;
      cmd.idx       = idx_ff;
      cmd.emit_last = row_end && col_end;

      case (state_ff)
         imm_pkg::ST_IDLE: begin
            req_stall = stat.mismatch && !stat.out_free;
            if (req_valid && !req_stall) begin
               if (stat.mismatch) begin
                  cmd.emit_mis = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  if (stat.last_load) begin
                     row_in        = '0;
                     col_in        = '0;
                     idx_in        = '0;
                     cmd.acc_clear = 1'b1;
                     state_in      = imm_pkg::ST_MAC;
                  end
               end
            end
         end
         imm_pkg::ST_MAC: begin
            cmd.issue = 1'b1;
            if (idx_end) begin
               idx_in   = '0;
               state_in = imm_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + imm_pkg::IDX_W'(1);
            end
         end
         imm_pkg::ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = imm_pkg::ST_EMIT;
            end
         end
         imm_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (row_end && col_end) begin
                  state_in = imm_pkg::ST_IDLE;
               end else begin
                  cmd.acc_clear = 1'b1;
                  state_in      = imm_pkg::ST_MAC;
                  if (col_end) begin
                     col_in = '0;
                     row_in = row_ff + imm_pkg::IDX_W'(1);
                  end else begin
                     col_in = col_ff + imm_pkg::IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = imm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/integer_matrix_multiply_top.sv
// Top level of the integer matrix multiplier: controller plus datapath.
// Depends on imm_pkg, imm_controller and imm_datapath.
`timescale 1ns / 1ps

// Usage:
//   Set rows_a, cols_a, rows_b, cols_b through the csr_ write port while idle;
//   any write restarts loading. Then send A row-major and B row-major on the
//   req_ channel, one word per cycle. The word that completes B starts the
//   product walk: for each product element, cols_a reads pass through the
//   single multiply-accumulate unit and its read/multiply/add pipeline;
//   the walk waits for the pipeline to drain, then loads the sum into the
//   output register. Elements leave on the rsp_ channel in row-major
//   order; the last one carries rsp_last_flag.
//   The input is stalled during the walk. If cols_a and rows_b differ, each
//   input word is dropped and answered by one mismatch word (status 1, last 1)
//   in the cycle after it, one word per cycle while rsp_ is not stalled.
//   A stalled rsp_ word holds; the walk waits for the output register to free.
//   Reset clears the dimension registers to 1, the load position and all
//   valid flags; the A and B stores keep no reset value.
module integer_matrix_multiply_top #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [imm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [imm_pkg::DIM_W-1:0]          csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [imm_pkg::DATA_W-1:0]  req_element_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [imm_pkg::IDX_W-1:0]          rsp_out_row,
   output logic [imm_pkg::IDX_W-1:0]          rsp_out_col,
   output logic signed [imm_pkg::DATA_W-1:0]  rsp_product_value,
   output logic                               rsp_status,
   output logic                               rsp_last_flag
);

   imm_pkg::ctrl_cmd_type  cmd;
   imm_pkg::dp_status_type stat;

   imm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   imm_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_element_value (req_element_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_status        (rsp_status),
      .rsp_last_flag     (rsp_last_flag),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

FILE: hw/rtl/imm_checker.sv
// Port-level assertions for the integer matrix multiplier, bound to the top.
// Depends on imm_pkg and integer_matrix_multiply_top.
`timescale 1ns / 1ps

module imm_protocol_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [imm_pkg::IDX_W-1:0]          rsp_out_row,
   input logic [imm_pkg::IDX_W-1:0]          rsp_out_col,
   input logic signed [imm_pkg::DATA_W-1:0]  rsp_product_value,
   input logic                               rsp_status,
   input logic                               rsp_last_flag
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product_value)
         && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_status) && $stable(rsp_last_flag))
      else $error("stalled result word changed");

   // Mismatch words are zero and close their group
   a_mismatch_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == imm_pkg::STATUS_MISMATCH) |->
         rsp_last_flag && (rsp_product_value == '0)
         && (rsp_out_row == '0) && (rsp_out_col == '0))
      else $error("malformed mismatch result");

   // Handshake outputs are known, and so are the flags of a valid word
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({rsp_valid, req_stall}) && (!rsp_valid
         || !$isunknown({rsp_status, rsp_last_flag, rsp_out_row, rsp_out_col})))
      else $error("unknown handshake or result flags");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind integer_matrix_multiply_top imm_protocol_checker u_imm_checker (.*);

FILE: tb/sv/imm_checker.sv
// Checker for the integer matrix multiplier: watches the csr_, req_ and rsp_ ports,
// predicts every product word and compares it with what the block emits.
// Depends on imm_pkg for widths, register indexes and status codes.
`timescale 1ns / 1ps

module imm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imm_pkg::DIM_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [imm_pkg::DATA_W-1:0] req_element_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [imm_pkg::IDX_W-1:0]         rsp_out_row,
   input  logic [imm_pkg::IDX_W-1:0]         rsp_out_col,
   input  logic signed [imm_pkg::DATA_W-1:0] rsp_product_value,
   input  logic                              rsp_status,
   input  logic                              rsp_last_flag,
   output int unsigned                       error_count,
   output int unsigned                       pending_words,
   output int unsigned                       words_checked
);
   import imm_pkg::*;

   localparam int unsigned DIM_MAX    = MAX_DIM_DEF;
   localparam int unsigned REPORT_MAX = 10;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              status;
      logic              last;
   } product_word_type;

   product_word_type  due_products[$];
   logic [DIM_W-1:0]  dim_regs [4];
   logic [DATA_W-1:0] a_mem [DIM_MAX*DIM_MAX];
   logic [DATA_W-1:0] b_mem [DIM_MAX*DIM_MAX];
   int unsigned       load_pos;
   int unsigned       errors  = 0;
   int unsigned       checked = 0;

   // Out-of-range dimensions act as the nearest legal size
   function automatic int unsigned used_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > DIM_MAX) begin
         return DIM_MAX;
      end
      return v;
   endfunction

   // Store one element; queue the whole product when it completes B
   task automatic absorb_element(input logic [DATA_W-1:0] v);
      int unsigned       ra, ca, rb, cb, na, nb, k, r, c, i;
      logic [DATA_W-1:0] sum;
      product_word_type  w;
      ra = used_dim(dim_regs[REG_ROWS_A]);
      ca = used_dim(dim_regs[REG_COLS_A]);
      rb = used_dim(dim_regs[REG_ROWS_B]);
      cb = used_dim(dim_regs[REG_COLS_B]);
      // inner sizes disagree: drop the word, answer with one mismatch word
      if (ca != rb) begin
         w = '{row: '0, col: '0, value: '0, status: STATUS_MISMATCH, last: 1'b1};
         due_products.push_back(w);
         return;
      end
      na = ra * ca;
      nb = rb * cb;
      if (load_pos < na) begin
         a_mem[(load_pos / ca) * DIM_MAX + load_pos % ca] = v;
      end else begin
         k = load_pos - na;
         b_mem[(k / cb) * DIM_MAX + k % cb] = v;
      end
      load_pos++;
      if (load_pos != na + nb) begin
         return;
      end
      load_pos = 0;
      // row-major walk, sums wrap at 32 bits
      for (r = 0; r < ra; r++) begin
         for (c = 0; c < cb; c++) begin
            sum = '0;
            for (i = 0; i < ca; i++) begin
               sum = sum + a_mem[r * DIM_MAX + i] * b_mem[i * DIM_MAX + c];
            end
            w.row    = IDX_W'(r);
            w.col    = IDX_W'(c);
            w.value  = sum;
            w.status = STATUS_OK;
            w.last   = (r + 1 == ra) && (c + 1 == cb);
            due_products.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      product_word_type w;
      if (reset) begin
         dim_regs[REG_ROWS_A] = DIM_W'(1);
         dim_regs[REG_COLS_A] = DIM_W'(1);
         dim_regs[REG_ROWS_B] = DIM_W'(1);
         dim_regs[REG_COLS_B] = DIM_W'(1);
         load_pos = 0;
         due_products.delete();
      end else begin
         // compare each emitted word with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (due_products.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX) begin
                  $display("[%0t] unexpected word: row %0d col %0d value %0d status %0d last %0d",
                           $realtime, rsp_out_row, rsp_out_col, rsp_product_value,
                           rsp_status, rsp_last_flag);
               end
            end else begin
               w = due_products.pop_front();
               if (rsp_out_row !== w.row || rsp_out_col !== w.col ||
                   rsp_product_value !== w.value || rsp_status !== w.status ||
                   rsp_last_flag !== w.last) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("[%0t] word %0d differs: expected row %0d col %0d value %0d",
                              $realtime, checked, w.row, w.col, $signed(w.value));
                     $display("   status %0d last %0d; got row %0d col %0d value %0d %s %0d %s %0d",
                              w.status, w.last, rsp_out_row, rsp_out_col,
                              rsp_product_value, "status", rsp_status, "last",
                              rsp_last_flag);
                  end
               end
            end
         end
         // any register write restarts loading; spare indexes change nothing
         if (csr_wr_en) begin
            case (csr_index)
               REG_ROWS_A: dim_regs[REG_ROWS_A] = csr_wr_data;
               REG_COLS_A: dim_regs[REG_COLS_A] = csr_wr_data;
               REG_ROWS_B: dim_regs[REG_ROWS_B] = csr_wr_data;
               REG_COLS_B: dim_regs[REG_COLS_B] = csr_wr_data;
               default: ;
            endcase
            load_pos = 0;
         end
         if (req_valid && !req_stall) begin
            absorb_element(req_element_value);
         end
      end
      error_count   <= errors;
      pending_words <= due_products.size();
      words_checked <= checked;
   end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the integer matrix multiplier: clock, reset, dimension setups
// and element stimulus, receiver stalls and the verdict.
// Depends on imm_pkg, integer_matrix_multiply_top and imm_checker.
`timescale 1ns / 1ps

module tb;
   import imm_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 2000000;
   localparam int unsigned SETTLE_CYCLES  = 2 * MAX_DIM_DEF + 8;
   localparam int unsigned ITEM_TARGET    = 320;
   localparam int unsigned SQUEEZE_CYCLES = 150;
   localparam int unsigned SQUEEZE_WORDS  = 24;
   localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM_DEF);
   // first index past the register list, and the highest index the port carries
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = REG_COLS_B + 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = '1;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     csr_wr_en         = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index         = '0;
   logic [DIM_W-1:0]         csr_wr_data       = '0;
   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall         = 1'b0;
   logic [IDX_W-1:0]         rsp_out_row;
   logic [IDX_W-1:0]         rsp_out_col;
   logic signed [DATA_W-1:0] rsp_product_value;
   logic                     rsp_status;
   logic                     rsp_last_flag;
   logic                     squeeze_req       = 1'b0;

   int unsigned error_count;
   int unsigned pending_words;
   int unsigned words_checked;
   int unsigned words_sent      = 0;
   int unsigned burst_left      = 0;
   int unsigned setups          = 0;
   int unsigned mismatch_setups = 0;
   int unsigned cycle_count     = 0;

   integer_matrix_multiply_top i_dut (.*);

   imm_checker i_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run if it goes on far beyond the slowest correct run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_words);
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver: stall in stretches of random density, plus one long hold on request
   initial begin
      int unsigned hold_left, mode_left, stall_pct;
      bit          squeezed;
      hold_left = 0;
      mode_left = 0;
      stall_pct = 0;
      squeezed  = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_req && !squeezed) begin
            squeezed  = 1'b1;
            hold_left = SQUEEZE_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(10, 100);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 20;
                  2: stall_pct = 50;
                  default: stall_pct = 90;
               endcase
            end
            mode_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Mostly random words, with extremes and small values mixed in
   function automatic logic [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return '1;
               default: return '0;
            endcase
         end
         1, 2, 3: return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
         default: return $urandom;
      endcase
   endfunction

   // Mostly small sizes, some up to the limit, a few out of range
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return DIM_W'($urandom_range(MAX_DIM_DEF + 1, 15));
         2, 3, 4: return DIM_W'($urandom_range(4, MAX_DIM_DEF));
         default: return DIM_W'($urandom_range(1, 3));
      endcase
   endfunction

   // Offer one word, with a random gap whenever a burst runs out
   task automatic send_element(input logic [DATA_W-1:0] v);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_valid         <= 1'b1;
      req_element_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic pause_sender();
      req_valid  <= 1'b0;
      burst_left = 0;
   endtask

   // Wait until every predicted word is out, then let the pipeline drain
   task automatic settle();
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic setup_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                             input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
      settle();
      write_reg(REG_ROWS_A, ra);
      write_reg(REG_COLS_A, ca);
      write_reg(REG_ROWS_B, rb);
      write_reg(REG_COLS_B, cb);
      csr_wr_en <= 1'b0;
      setups++;
      if (eff_dim(ca, DIM_LIMIT) != eff_dim(rb, DIM_LIMIT)) begin
         mismatch_setups++;
      end
   endtask

   initial begin
      logic [DIM_W-1:0] ra, ca, rb, cb;
      int unsigned      pair_words, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // 1x1 by 1x1 after reset: products that wrap
      send_element(32'h8000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'h7FFF_FFFF);
      send_element(32'h7FFF_FFFF);
      pause_sender();

      // zero and oversized registers act as 1 and 8: row of 8 times column of 8
      setup_dims(4'd0, 4'd9, 4'd8, 4'd0);
      for (n = 0; n < 16; n++) begin
         send_element({n[0], {(DATA_W-1){n[1]}}});
      end
      pause_sender();

      // inner sizes differ: each word dropped
      setup_dims(4'd0, 4'd2, 4'd3, 4'd0);
      send_element(rand_element());
      send_element(rand_element());
      pause_sender();

      // half-loaded pair, then a write to a spare index restarts loading
      setup_dims(4'd1, 4'd1, 4'd1, 4'd1);
      send_element(rand_element());
      pause_sender();
      settle();
      write_reg(REG_SPARE_LO, '1);
      csr_wr_en <= 1'b0;
      send_element(32'h0000_0003);
      send_element(32'hFFFF_FFFB);
      pause_sender();

      // widest fan-out: 8x1 times 1x8 gives a full 8x8 product
      setup_dims(4'd8, 4'd1, 4'd1, 4'd8);
      repeat (16) send_element(rand_element());
      pause_sender();

      // hold the receiver off while mismatch words pile up and back up the input
      setup_dims(pick_dim(), 4'd3, 4'd5, pick_dim());
      squeeze_req <= 1'b1;
      repeat (SQUEEZE_WORDS) send_element(rand_element());
      pause_sender();

      // random setups until enough words have gone in
      while (words_sent < ITEM_TARGET) begin
         ra = pick_dim();
         ca = pick_dim();
         cb = pick_dim();
         if ($urandom_range(0, 5) == 0) begin
            do begin
               rb = pick_dim();
            end while (eff_dim(rb, DIM_LIMIT) == eff_dim(ca, DIM_LIMIT));
            setup_dims(ra, ca, rb, cb);
            repeat ($urandom_range(1, 8)) send_element(rand_element());
         end else begin
            // same used inner size, sometimes through different register bits
            if (eff_dim(ca, DIM_LIMIT) == 1) begin
               rb = DIM_W'($urandom_range(0, 1));
            end else if (eff_dim(ca, DIM_LIMIT) == DIM_LIMIT) begin
               rb = DIM_W'($urandom_range(MAX_DIM_DEF, 15));
            end else begin
               rb = ca;
            end
            setup_dims(ra, ca, rb, cb);
            pair_words = eff_dim(ra, DIM_LIMIT) * eff_dim(ca, DIM_LIMIT) +
                         eff_dim(rb, DIM_LIMIT) * eff_dim(cb, DIM_LIMIT);
            repeat ($urandom_range(1, 3) * pair_words) send_element(rand_element());
            // now and then abandon a pair halfway and restart loading
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, pair_words - 1)) send_element(rand_element());
               pause_sender();
               settle();
               if ($urandom_range(0, 1) == 0) begin
                  write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                            DIM_W'($urandom));
               end else begin
                  write_reg(REG_COLS_B, cb);
               end
               csr_wr_en <= 1'b0;
               repeat (pair_words) send_element(rand_element());
            end
         end
         pause_sender();
      end

      settle();
      $display("Sent %0d element words over %0d dimension setups (%0d with unequal inner sizes),",
               words_sent, setups, mismatch_setups);
      $display("checked %0d result words under bursty input, random stalls and one long hold.",
               words_checked);
      if (pending_words != 0) begin
         $display("%0d predicted words never arrived", pending_words);
      end
      if (error_count == 0 && pending_words == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
